### rtl/core/cmme_pkg.sv
// shared types and constants for the cigar match/mismatch expander
package cmme_pkg;

    // run length parameter of the scheme, capped by the width of the length fields
    localparam int LENGTH_BITS = 28;
    localparam int LEN_W       = 28;

    localparam logic [LEN_W-1:0] RUN_MAX = (LENGTH_BITS >= LEN_W) ? {LEN_W{1'b1}} :
        LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

    // cigar codes produced for runs
    localparam logic [3:0] CODE_EQ = 4'd7;
    localparam logic [3:0] CODE_X  = 4'd8;

    // item kinds
    localparam logic OP_PASS   = 1'b0;
    localparam logic OP_COLUMN = 1'b1;

    // queue depth of the result buffer
    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    typedef struct packed {
        logic             op;
        logic [3:0]       op_type;
        logic [LEN_W-1:0] op_length;
        logic [7:0]       query_base;
        logic [7:0]       ref_base;
        logic             op_end;
    } in_item_t;

    typedef struct packed {
        logic [3:0]       code;
        logic [LEN_W-1:0] length;
        logic             last;
    } result_t;

    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } res_pair_t;

endpackage

### rtl/core/cigar_match_mismatch_expander.sv
// top level of the cigar match/mismatch expander
// an item passes the input register and then the result queue on its way to the output
// throughput: one item per cycle while each item yields at most one result and the sink is ready;
//   an item that yields two results waits until the queue is empty after the pop
// the two-slot result queue sets the rate: an item advances when its results fit
// reset: rst_n clears the run state, the input valid flag and the result queue count at once
module cigar_match_mismatch_expander
    import cmme_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // op_type[3:0], op_length[31:4], query_base[39:32], ref_base[47:40]
    input  logic        s_axis_tuser,  // op: 0 whole operation, 1 column of an m operation
    input  logic        s_axis_tlast,  // op_end

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // out_type[3:0], out_length[31:4]
    output logic        m_axis_tlast   // last result of the item
);

    // input register
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    in_item_t  in_item_now;

    // run logic and queue hookup
    res_pair_t  results;
    logic       advance;
    logic       pop;
    logic [1:0] q_count;
    logic [2:0] q_after;
    result_t    head;

    assign in_item_now.op         = s_axis_tuser;
    assign in_item_now.op_type    = s_axis_tdata[3:0];
    assign in_item_now.op_length  = s_axis_tdata[31:4];
    assign in_item_now.query_base = s_axis_tdata[39:32];
    assign in_item_now.ref_base   = s_axis_tdata[47:40];
    assign in_item_now.op_end     = s_axis_tlast;

    // output side pops the head when the sink takes it
    assign pop = m_axis_tvalid && m_axis_tready;

    // room left after the pop must hold every result of the held item
    assign q_after = {1'b0, q_count} - {2'b0, pop} + {1'b0, results.num};
    assign advance = in_valid_reg && (q_after <= {1'b0, QUEUE_DEPTH});

    // a new item enters when the input register is empty or the held one leaves this cycle
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_item_reg <= in_item_now;
    end

    // compare, run update and result selection
    cmme_run_logic u_run_logic (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (in_item_reg),
        .advance (advance),
        .results (results)
    );

    // push only on the cycle the held item advances
    res_pair_t push;

    always_comb
    begin
        push     = results;
        push.num = advance ? results.num : 2'd0;
    end

    cmme_result_queue u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .count (q_count),
        .head  (head)
    );

    assign m_axis_tvalid = q_count != 2'd0;
    assign m_axis_tdata  = {head.length, head.code};
    assign m_axis_tlast  = head.last;

    // the held item only advances from a filled input register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> in_valid_reg)
        else $error("advance without a held item");

endmodule

### rtl/core/cmme_run_logic.sv
// run state and result computation for one item
module cmme_run_logic
    import cmme_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  item,
    input  logic      advance,
    output res_pair_t results
);

    logic             run_open_reg, run_open_next;
    logic             run_mis_reg, run_mis_next;
    logic [LEN_W-1:0] run_count_reg, run_count_next;

    logic             mis;
    logic             limit_hit;
    logic             close_old;
    logic             grow;
    logic [LEN_W-1:0] col_count;
    logic [LEN_W-1:0] len_sat;
    logic             have_old;
    logic             have_new;
    result_t          old_res;
    result_t          new_res;

    assign mis       = item.query_base != item.ref_base;
    assign limit_hit = run_count_reg >= RUN_MAX;
    assign close_old = run_open_reg && ((mis != run_mis_reg) || limit_hit);
    assign grow      = run_open_reg && !close_old;
    assign col_count = grow ? (run_count_reg + LEN_W'(1)) : LEN_W'(1);
    assign len_sat   = (item.op_length > RUN_MAX) ? RUN_MAX : item.op_length;

    always_comb
    begin
        old_res.code   = run_mis_reg ? CODE_X : CODE_EQ;
        old_res.length = run_count_reg;
        old_res.last   = 1'b0;

        if (item.op == OP_PASS)
        begin
            // pending run closes as if op_end had been seen
            have_old       = run_open_reg;
            have_new       = len_sat != '0;
            new_res.code   = item.op_type;
            new_res.length = len_sat;
            new_res.last   = 1'b1;
            run_open_next  = 1'b0;
            run_mis_next   = 1'b0;
            run_count_next = '0;
        end
        else
        begin
            have_old       = close_old;
            have_new       = item.op_end;
            new_res.code   = mis ? CODE_X : CODE_EQ;
            new_res.length = col_count;
            new_res.last   = 1'b1;
            run_open_next  = !item.op_end;
            run_mis_next   = item.op_end ? 1'b0 : mis;
            run_count_next = item.op_end ? '0 : col_count;
        end

        results.num         = {1'b0, have_old} + {1'b0, have_new};
        results.first       = have_old ? old_res : new_res;
        results.first.last  = !(have_old && have_new);
        results.second      = new_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg  <= 1'b0;
            run_mis_reg   <= 1'b0;
            run_count_reg <= '0;
        end
        else if (advance)
        begin
            run_open_reg  <= run_open_next;
            run_mis_reg   <= run_mis_next;
            run_count_reg <= run_count_next;
        end
    end

    // an open run always holds at least one column
    assert property (@(posedge clk) disable iff (!rst_n)
        run_open_reg == (run_count_reg != '0))
        else $error("run open flag and run count disagree");

    // the last column of an operation leaves no run open
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item.op == OP_COLUMN && item.op_end) |=> !run_open_reg)
        else $error("run still open after op_end");

endmodule

### rtl/core/cmme_result_queue.sv
// two-entry result queue that feeds the output channel
module cmme_result_queue
    import cmme_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  res_pair_t  push,
    input  logic       pop,
    output logic [1:0] count,
    output result_t    head
);

    result_t    e0_reg, e0_next;
    result_t    e1_reg, e1_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] cnt_p;

    assign cnt_p = count_reg - {1'b0, pop};

    always_comb
    begin
        if (cnt_p == 2'd0 && push.num != 2'd0)
            e0_next = push.first;
        else if (pop)
            e0_next = e1_reg;
        else
            e0_next = e0_reg;

        if (cnt_p == 2'd1 && push.num != 2'd0)
            e1_next = push.first;
        else if (cnt_p == 2'd0 && push.num == 2'd2)
            e1_next = push.second;
        else
            e1_next = e1_reg;

        count_next = cnt_p + push.num;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    assign count = count_reg;
    assign head  = e0_reg;

    // occupancy never runs past the two slots
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_DEPTH)
        else $error("result queue overflow");

    // a two-result push needs both slots free after the pop
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.num == 2'd2) |-> (cnt_p == 2'd0))
        else $error("double push into occupied queue");

endmodule

### tb/sv/cmme_checker.sv
// checker that predicts and compares the expander's result items
`timescale 1ns / 1ps

module cmme_checker
    import cmme_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // op_type[3:0], op_length[31:4], query_base[39:32], ref_base[47:40]
    input  logic        s_axis_tuser,  // op
    input  logic        s_axis_tlast,  // op_end

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,  // out_type[3:0], out_length[31:4]
    input  logic        m_axis_tlast,  // last

    output int          errors,
    output int          pending
);

    // open run of the predictor
    logic             run_open;
    logic             run_mis;
    logic [LEN_W-1:0] run_len;

    // cigar ops predicted but not yet seen on the output
    result_t predicted_ops [$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (errors < 200)
            $display("%0t ns: mismatch on %s, got 0x%0h, predicted 0x%0h",
                     $time, what, got, want);
        errors++;
    endtask

    // emit the open run and close it
    function automatic result_t close_run();
        result_t r;
        r.code   = run_mis ? CODE_X : CODE_EQ;
        r.length = run_len;
        r.last   = 1'b0;
        run_open = 1'b0;
        run_mis  = 1'b0;
        run_len  = '0;
        return r;
    endfunction

    function automatic void expand_item(input in_item_t it);
        result_t          res [2];
        int               n;
        logic             mis;
        n = 0;
        if (it.op == OP_PASS)
        begin
            // a pass op ends any open run, as if op_end had come
            if (run_open)
            begin
                res[n] = close_run();
                n++;
            end
            if (it.op_length != '0)
            begin
                res[n].code   = it.op_type;
                res[n].length = (it.op_length > RUN_MAX) ? RUN_MAX : it.op_length;
                res[n].last   = 1'b0;
                n++;
            end
        end
        else
        begin
            mis = (it.query_base != it.ref_base);
            if (run_open && (mis != run_mis || run_len >= RUN_MAX))
            begin
                res[n] = close_run();
                n++;
            end
            if (!run_open)
            begin
                run_open = 1'b1;
                run_mis  = mis;
                run_len  = '0;
            end
            run_len = run_len + LEN_W'(1);
            if (it.op_end)
            begin
                res[n] = close_run();
                n++;
            end
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            predicted_ops.push_back(res[i]);
    endfunction

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            run_open = 1'b0;
            run_mis  = 1'b0;
            run_len  = '0;
            predicted_ops.delete();
            pending <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[3:0], m_axis_tdata[31:4], m_axis_tlast};
                if (predicted_ops.size() == 0)
                    report("result with nothing predicted", m_axis_tdata, '0);
                else
                begin
                    want = predicted_ops.pop_front();
                    if (got.code != want.code)
                        report("out_type", 32'(got.code), 32'(want.code));
                    if (got.length != want.length)
                        report("out_length", 32'(got.length), 32'(want.length));
                    if (got.last != want.last)
                        report("last", 32'(got.last), 32'(want.last));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expand_item({s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[31:4],
                             s_axis_tdata[39:32], s_axis_tdata[47:40], s_axis_tlast});
            pending <= predicted_ops.size();
        end
    end

endmodule

### tb/sv/tb_cigar_match_mismatch_expander.sv
// testbench top for the cigar match/mismatch expander: stimulus and verdict
`timescale 1ns / 1ps

module tb_cigar_match_mismatch_expander;
    import cmme_pkg::*;

    // sam cigar codes used for pass-through ops
    localparam logic [3:0] CIGAR_M     = 4'd0;
    localparam logic [3:0] CIGAR_I     = 4'd1;
    localparam logic [3:0] CIGAR_D     = 4'd2;
    localparam logic [3:0] CIGAR_N     = 4'd3;
    localparam logic [3:0] CIGAR_S     = 4'd4;
    localparam logic [3:0] CIGAR_H     = 4'd5;
    localparam logic [3:0] CIGAR_P     = 4'd6;
    localparam logic [3:0] CIGAR_UNDEF = 4'd15;  // no meaning, still passed as given

    // nucleotide letters for realistic columns
    localparam logic [7:0] BASE_A = 8'h41;
    localparam logic [7:0] BASE_C = 8'h43;
    localparam logic [7:0] BASE_G = 8'h47;
    localparam logic [7:0] BASE_T = 8'h54;
    localparam logic [7:0] NUCLEOTIDES [4] = '{BASE_A, BASE_C, BASE_G, BASE_T};

    localparam int RANDOM_ITEMS = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;  // op_type[3:0], op_length[31:4], query_base[39:32], ref_base[47:40]
    logic        s_axis_tuser = 1'b0; // op
    logic        s_axis_tlast = 1'b0; // op_end

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;       // out_type[3:0], out_length[31:4]
    logic        m_axis_tlast;       // last

    int          errors;
    int          pending;
    int          items_sent = 0;
    bit          no_idle = 1'b0;     // set for stretches with back-to-back traffic

    always #10 clk = ~clk;

    cigar_match_mismatch_expander u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    cmme_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (errors),
        .pending       (pending)
    );

    // idle cycles before the next item on either side
    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    // drive one item and hold it until the block takes it;
    // called at a rising edge, returns at the edge of acceptance
    task automatic send_item(input logic op, input logic [3:0] code, input logic [LEN_W-1:0] len,
                             input logic [7:0] qb, input logic [7:0] rb, input logic op_end);
        int gap;
        gap = idle_draw();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tlast  <= op_end;
        s_axis_tdata  <= {rb, qb, len, code};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    // whole non-m op; the column fields carry noise
    task automatic send_pass(input logic [3:0] code, input logic [LEN_W-1:0] len);
        send_item(OP_PASS, code, len, 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // one column of an m op; the pass fields carry noise
    task automatic send_column(input logic [7:0] qb, input logic [7:0] rb, input logic op_end);
        send_item(OP_COLUMN, 4'($urandom), LEN_W'($urandom), qb, rb, op_end);
    endtask

    // hold off the sender until every predicted op has come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // receiver: after each accepted result, stall a random number of cycles
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        m_axis_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                stall = idle_draw();
                if (stall != 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int               n_ops;
        int               cols;
        int               mis_pct;
        int               pick;
        bit               truncated;
        logic [3:0]       code;
        logic [LEN_W-1:0] len;
        logic [7:0]       qb;
        logic [7:0]       rb;
        int               stop_at;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pass-through ops, zero length dropped, undefined code and full length kept
        send_pass(CIGAR_S, 28'd5);
        send_pass(CIGAR_D, '0);
        send_pass(CIGAR_M, 28'd1);
        send_pass(CIGAR_UNDEF, '1);
        // plain match run closed by op_end
        send_column(BASE_A, BASE_A, 1'b0);
        send_column(BASE_C, BASE_C, 1'b1);
        // single mismatch column with extreme bytes
        send_column(8'h00, 8'hFF, 1'b1);
        // class change inside an m op, extreme equal bytes
        send_column(8'hFF, 8'hFF, 1'b0);
        send_column(8'h00, 8'h00, 1'b0);
        send_column(BASE_G, BASE_T, 1'b0);
        send_column(BASE_T, BASE_G, 1'b1);
        // one column closing the old run and its own run at once
        send_column(BASE_A, BASE_A, 1'b0);
        send_column(BASE_A, BASE_C, 1'b1);
        // pass op arriving with a run still open
        send_column(BASE_C, BASE_T, 1'b0);
        send_pass(CIGAR_I, 28'd7);
        // zero-length pass op with a run open: only the run comes out
        send_column(BASE_G, BASE_G, 1'b0);
        send_pass(CIGAR_N, '0);
        // remaining codes and alternating length bits
        send_pass(CODE_EQ, 28'd3);
        send_pass(CODE_X, 28'd2);
        send_pass(CIGAR_H, 28'h5A5A5A5);
        send_pass(CIGAR_P, 28'hA5A5A5A);
        drain_results();

        // random cigar records: m ops as column streams between pass ops
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 7) == 0)
                drain_results();
            n_ops = $urandom_range(1, 6);
            for (int k = 0; k < n_ops; k++)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    code = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
                    pick = $urandom_range(0, 9);
                    case (pick)
                        0:       len = '0;
                        1:       len = '1;
                        2:       len = LEN_W'($urandom);
                        default: len = LEN_W'($urandom_range(1, 500));
                    endcase
                    send_pass(code, len);
                end
                else
                begin
                    cols      = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                            : $urandom_range(1, 12);
                    mis_pct   = $urandom_range(0, 4) * 25;
                    // now and then an m op ends without op_end
                    truncated = ($urandom_range(0, 9) == 0);
                    for (int c = 0; c < cols; c++)
                    begin
                        if ($urandom_range(0, 7) == 0)
                            rb = 8'($urandom);
                        else
                            rb = NUCLEOTIDES[$urandom_range(0, 3)];
                        if ($urandom_range(1, 100) <= mis_pct)
                            qb = rb ^ 8'($urandom_range(1, 255));
                        else
                            qb = rb;
                        send_column(qb, rb, (c == cols - 1) && !truncated);
                    end
                end
            end
        end

        // let the last results come out, then a few quiet cycles for stray ones
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;
        for (int i = 0; i < 20000 && pending != 0; i++)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog for a hung handshake
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
